>>> sv/lca_bl_pkg.sv
// Shared constants for the lowest-common-ancestor core: field widths,
// item function codes and default sizes.
// No dependencies; compile first.
package lca_bl_pkg;

  // Payload field widths
  localparam int NODE_W = 10;
  localparam int FUNC_W = 2;

  // Item function codes
  localparam logic [FUNC_W-1:0] FUNC_LOAD  = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_BUILD = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_QUERY = 2'd2;

  // Default sizes
  localparam int NODES_DEF    = 1024;
  localparam int LEVELS_DEF   = 11;
  localparam int JUMP_AW_DEF  = $clog2(NODES_DEF) + $clog2(LEVELS_DEF);
  localparam int DEPTH_AW_DEF = $clog2(NODES_DEF);

endpackage

>>> sv/lca_bl_req_if.sv
// Request channel: valid/ready handshake carrying one input item.
// Depends on lca_bl_pkg.
interface lca_bl_req_if;
  logic                            valid;
  logic                            ready;
  logic [lca_bl_pkg::FUNC_W-1:0]   func;
  logic [lca_bl_pkg::NODE_W-1:0]   node_a;
  logic [lca_bl_pkg::NODE_W-1:0]   node_b;

  modport source (output valid, func, node_a, node_b, input ready);
  modport sink   (input valid, func, node_a, node_b, output ready);
endinterface

>>> sv/lca_bl_rsp_if.sv
// Response channel: valid/ready handshake carrying one result item.
// Depends on lca_bl_pkg.
interface lca_bl_rsp_if;
  logic                            valid;
  logic                            ready;
  logic [lca_bl_pkg::NODE_W-1:0]   ancestor;
  logic                            bad_node;

  modport source (output valid, ancestor, bad_node, input ready);
  modport sink   (input valid, ancestor, bad_node, output ready);
endinterface

>>> sv/lca_bl_jump_mem.sv
// Jump table storage: one write port, two registered read ports.
// Depends on lca_bl_pkg for default sizes.
module lca_bl_jump_mem #(
  parameter int ADDR_W = lca_bl_pkg::JUMP_AW_DEF,
  parameter int DATA_W = lca_bl_pkg::NODE_W
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic [ADDR_W-1:0] ra_addr,
  input  logic [ADDR_W-1:0] rb_addr,
  output logic [DATA_W-1:0] qa,
  output logic [DATA_W-1:0] qb
);

  logic [DATA_W-1:0] mem [2**ADDR_W];

  // Write one entry, read two entries every cycle
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    qa <= mem[ra_addr];
    qb <= mem[rb_addr];
  end

endmodule

>>> sv/lca_bl_depth_mem.sv
// Node depth storage: one write port, one registered read port.
// Depends on lca_bl_pkg for default sizes.
module lca_bl_depth_mem #(
  parameter int ADDR_W = lca_bl_pkg::DEPTH_AW_DEF,
  parameter int DATA_W = lca_bl_pkg::LEVELS_DEF
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] q
);

  logic [DATA_W-1:0] mem [2**ADDR_W];

  // Write one entry, read one entry every cycle
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    q <= mem[raddr];
  end

endmodule

>>> sv/lca_binary_lifting_core.sv
// Load: written from the idle state. Build: a doubling pass, then a depth pass,
// over nodes 1..min(node_count, NODES-1). Query: both depths fetched, then one
// jump table read per lift or descent step (no descent when lifting meets the
// other node, no walk for a node out of use); a waiting result holds it back;
// next item the cycle after. Reset clears the jump table, one entry a cycle,
// all 2^(clog2(NODES)+clog2(LEVELS)) entries (16384 at defaults), req.ready low.
module lca_binary_lifting_core #(
  parameter int NODES  = lca_bl_pkg::NODES_DEF,
  parameter int LEVELS = lca_bl_pkg::LEVELS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [lca_bl_pkg::NODE_W-1:0] cfg_wdata,
  lca_bl_req_if.sink                    req,
  lca_bl_rsp_if.source                  rsp
);

  localparam int NW = lca_bl_pkg::NODE_W;
  localparam int RB = $clog2(NODES);
  localparam int LB = $clog2(LEVELS);
  localparam int AW = RB + LB;
  localparam int DW = LEVELS;
  localparam logic [LB-1:0] LVL_TOP = LB'(LEVELS - 1);

  typedef enum logic [14:0] {
    S_CLEAR       = 15'b000000000000001,
    S_IDLE        = 15'b000000000000010,
    S_BUILD_A     = 15'b000000000000100,
    S_BUILD_B     = 15'b000000000001000,
    S_BUILD_W     = 15'b000000000010000,
    S_DEPTH_START = 15'b000000000100000,
    S_DEPTH       = 15'b000000001000000,
    S_DEPTH_W     = 15'b000000010000000,
    S_Q_DB        = 15'b000000100000000,
    S_Q_SWAP      = 15'b000001000000000,
    S_LIFT        = 15'b000010000000000,
    S_LIFT_END    = 15'b000100000000000,
    S_DESC        = 15'b001000000000000,
    S_FINAL       = 15'b010000000000000,
    S_DONE        = 15'b100000000000000
  } state_t;

  // Table address of node at level
  function automatic logic [AW-1:0] jaddr(input logic [NW-1:0] node,
                                          input logic [LB-1:0] level);
    jaddr = {RB'(node), level};
  endfunction

  // Node has no row in the table
  function automatic logic off_tab(input logic [NW-1:0] node);
    off_tab = (32'(node) >= NODES);
  endfunction

  state_t        state, state_next;
  logic [AW-1:0] clr_addr, clr_addr_next;
  logic [NW-1:0] node_count;
  logic [NW-1:0] top, top_next;
  logic [NW-1:0] v, v_next;
  logic [LB-1:0] lvl, lvl_next;
  logic [NW-1:0] x, x_next;
  logic [NW-1:0] y, y_next;
  logic [DW-1:0] d, d_next;
  logic [DW-1:0] da, da_next;
  logic          pend, pend_next;
  logic          za, zb;
  logic [NW-1:0] res_anc, res_anc_next;
  logic          res_bad, res_bad_next;
  logic          out_valid, out_valid_next;
  logic [NW-1:0] out_anc, out_anc_next;
  logic          out_bad, out_bad_next;

  // Memory ports
  logic [NW-1:0] ra_node, rb_node;
  logic [LB-1:0] ra_lvl, rb_lvl;
  logic [NW-1:0] qa, qb, ha, hb;
  logic          jwe;
  logic [AW-1:0] jwaddr;
  logic [NW-1:0] jwdata;
  logic          dwe;
  logic [RB-1:0] dwaddr, draddr;
  logic [DW-1:0] dwdata, dq;

  // Step values
  logic [NW-1:0] x_cur, xn, yn, last;
  logic          accept, a_ok, b_ok, load_ok;

  lca_bl_jump_mem #(.ADDR_W(AW), .DATA_W(NW)) u_jump (
    .clk     (clk),
    .we      (jwe),
    .waddr   (jwaddr),
    .wdata   (jwdata),
    .ra_addr (jaddr(ra_node, ra_lvl)),
    .rb_addr (jaddr(rb_node, rb_lvl)),
    .qa      (qa),
    .qb      (qb)
  );

  lca_bl_depth_mem #(.ADDR_W(RB), .DATA_W(DW)) u_depth (
    .clk   (clk),
    .we    (dwe),
    .waddr (dwaddr),
    .wdata (dwdata),
    .raddr (draddr),
    .q     (dq)
  );

  // Hop results: nodes without a row read as the sentinel
  assign ha = za ? '0 : qa;
  assign hb = zb ? '0 : qb;

  assign accept  = req.valid && req.ready;
  assign a_ok    = (req.node_a != '0) && (req.node_a <= node_count) && !off_tab(req.node_a);
  assign b_ok    = (req.node_b != '0) && (req.node_b <= node_count) && !off_tab(req.node_b);
  assign load_ok = (req.node_a >= NW'(2)) && a_ok;
  assign last    = (32'(node_count) < NODES) ? node_count : NW'(NODES - 1);

  assign req.ready    = (state == S_IDLE);
  assign rsp.valid    = out_valid;
  assign rsp.ancestor = out_anc;
  assign rsp.bad_node = out_bad;

  // Sequencer: issue reads, walk the table, write back
  always_comb begin
    state_next    = state;
    clr_addr_next = clr_addr;
    top_next      = top;
    v_next        = v;
    lvl_next      = lvl;
    x_next        = x;
    y_next        = y;
    d_next        = d;
    da_next       = da;
    pend_next     = pend;
    res_anc_next  = res_anc;
    res_bad_next  = res_bad;
    ra_node       = x;
    rb_node       = y;
    ra_lvl        = lvl;
    rb_lvl        = lvl;
    jwe           = 1'b0;
    jwaddr        = jaddr(v, lvl);
    jwdata        = ha;
    dwe           = 1'b0;
    dwaddr        = RB'(v);
    dwdata        = d;
    draddr        = RB'(req.node_a);
    x_cur         = pend ? ha : x;
    xn            = (ha != hb) ? ha : x;
    yn            = (ha != hb) ? hb : y;

    unique case (state)
      S_CLEAR: begin
        jwe           = 1'b1;
        jwaddr        = clr_addr;
        jwdata        = '0;
        clr_addr_next = clr_addr + AW'(1);
        if (&clr_addr) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          case (req.func)
            lca_bl_pkg::FUNC_LOAD: begin
              if (load_ok) begin
                jwe    = 1'b1;
                jwaddr = jaddr(req.node_a, '0);
                jwdata = req.node_b;
              end
            end
            lca_bl_pkg::FUNC_BUILD: begin
              top_next   = last;
              v_next     = NW'(1);
              lvl_next   = LB'(1);
              state_next = S_BUILD_A;
            end
            lca_bl_pkg::FUNC_QUERY: begin
              if (a_ok && b_ok) begin
                x_next     = req.node_a;
                y_next     = req.node_b;
                state_next = S_Q_DB;
              end else begin
                res_anc_next = '0;
                res_bad_next = 1'b1;
                state_next   = S_DONE;
              end
            end
            default: ;
          endcase
        end
      end
      // Pointer doubling: entry [v][lvl] = hop(hop(v, lvl-1), lvl-1)
      S_BUILD_A: begin
        ra_node    = v;
        ra_lvl     = lvl - LB'(1);
        // Skip the whole build when no node is in use
        if (top == '0) begin
          state_next = S_IDLE;
        end else begin
          state_next = S_BUILD_B;
        end
      end
      S_BUILD_B: begin
        ra_node    = ha;
        ra_lvl     = lvl - LB'(1);
        state_next = S_BUILD_W;
      end
      S_BUILD_W: begin
        jwe        = 1'b1;
        jwaddr     = jaddr(v, lvl);
        jwdata     = ha;
        state_next = S_BUILD_A;
        if (v == top) begin
          v_next = NW'(1);
          if (lvl == LVL_TOP) begin
            state_next = S_DEPTH_START;
          end else begin
            lvl_next = lvl + LB'(1);
          end
        end else begin
          v_next = v + NW'(1);
        end
      end
      // Depth: climb from the top level down, summing taken hops
      S_DEPTH_START: begin
        ra_node    = v;
        ra_lvl     = LVL_TOP;
        x_next     = v;
        d_next     = '0;
        lvl_next   = LVL_TOP;
        state_next = S_DEPTH;
      end
      S_DEPTH: begin
        if (ha != '0) begin
          x_next = ha;
          d_next = d + (DW'(1) << lvl);
        end
        if (lvl == '0) begin
          state_next = S_DEPTH_W;
        end else begin
          ra_node  = (ha != '0) ? ha : x;
          ra_lvl   = lvl - LB'(1);
          lvl_next = lvl - LB'(1);
        end
      end
      S_DEPTH_W: begin
        dwe    = 1'b1;
        dwaddr = RB'(v);
        dwdata = d;
        if (v == top) begin
          state_next = S_IDLE;
        end else begin
          v_next     = v + NW'(1);
          state_next = S_DEPTH_START;
        end
      end
      // Query: fetch both depths, order so x is the deeper node
      S_Q_DB: begin
        da_next    = dq;
        draddr     = RB'(y);
        state_next = S_Q_SWAP;
      end
      S_Q_SWAP: begin
        if (dq > da) begin
          x_next = y;
          y_next = x;
          d_next = dq - da;
        end else begin
          d_next = da - dq;
        end
        lvl_next   = '0;
        pend_next  = 1'b0;
        state_next = S_LIFT;
      end
      // Lift x by the depth difference, one level a cycle
      S_LIFT: begin
        x_next    = x_cur;
        ra_node   = x_cur;
        ra_lvl    = lvl;
        pend_next = d[lvl];
        if (lvl == LVL_TOP) begin
          state_next = S_LIFT_END;
        end else begin
          lvl_next = lvl + LB'(1);
        end
      end
      S_LIFT_END: begin
        x_next = x_cur;
        if (x_cur == y) begin
          res_anc_next = x_cur;
          res_bad_next = 1'b0;
          state_next   = S_DONE;
        end else begin
          ra_node    = x_cur;
          rb_node    = y;
          ra_lvl     = LVL_TOP;
          rb_lvl     = LVL_TOP;
          lvl_next   = LVL_TOP;
          state_next = S_DESC;
        end
      end
      // Descend: move both while their ancestors differ
      S_DESC: begin
        x_next = xn;
        y_next = yn;
        if (lvl == '0) begin
          ra_node    = xn;
          ra_lvl     = '0;
          state_next = S_FINAL;
        end else begin
          ra_node  = xn;
          rb_node  = yn;
          ra_lvl   = lvl - LB'(1);
          rb_lvl   = lvl - LB'(1);
          lvl_next = lvl - LB'(1);
        end
      end
      S_FINAL: begin
        res_anc_next = ha;
        res_bad_next = 1'b0;
        state_next   = S_DONE;
      end
      S_DONE: begin
        if (!out_valid || rsp.ready) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Output register: drain on ready, load a finished result
  always_comb begin
    out_valid_next = out_valid && !rsp.ready;
    out_anc_next   = out_anc;
    out_bad_next   = out_bad;
    if ((state == S_DONE) && (!out_valid || rsp.ready)) begin
      out_valid_next = 1'b1;
      out_anc_next   = res_anc;
      out_bad_next   = res_bad;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      clr_addr   <= '0;
      node_count <= NW'(1);
      pend       <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state     <= state_next;
      clr_addr  <= clr_addr_next;
      pend      <= pend_next;
      out_valid <= out_valid_next;
      if (cfg_we) begin
        node_count <= cfg_wdata;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    top     <= top_next;
    v       <= v_next;
    lvl     <= lvl_next;
    x       <= x_next;
    y       <= y_next;
    d       <= d_next;
    da      <= da_next;
    za      <= off_tab(ra_node);
    zb      <= off_tab(rb_node);
    res_anc <= res_anc_next;
    res_bad <= res_bad_next;
    out_anc <= out_anc_next;
    out_bad <= out_bad_next;
  end

endmodule

>>> sv/lca_bl_checker.sv
// Port-level checks for the lowest-common-ancestor core, bound to the core.
// Depends on lca_bl_pkg and lca_binary_lifting_core.
module lca_bl_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            req_valid,
  input logic                            req_ready,
  input logic [lca_bl_pkg::FUNC_W-1:0]   req_func,
  input logic                            rsp_valid,
  input logic                            rsp_ready,
  input logic [lca_bl_pkg::NODE_W-1:0]   rsp_ancestor,
  input logic                            rsp_bad_node
);

  // Reset empties the output and starts the clearing pass
  a_reset_quiet: assert property (@(posedge clk)
    rst |=> (!rsp_valid && !req_ready))
    else $error("output valid or input ready right after reset");

  // Stalled result holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp_ready) |=>
      (rsp_valid && $stable(rsp_ancestor) && $stable(rsp_bad_node)))
    else $error("result changed while stalled");

  // Rejected query reports the sentinel
  a_bad_zero: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp_bad_node) |-> (rsp_ancestor == '0))
    else $error("bad node result with nonzero ancestor");

  // Query and build items occupy the core
  a_busy: assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready &&
     ((req_func == lca_bl_pkg::FUNC_QUERY) || (req_func == lca_bl_pkg::FUNC_BUILD)))
      |=> !req_ready)
    else $error("input ready right after query or build item");

endmodule

bind lca_binary_lifting_core lca_bl_checker u_lca_bl_checker (
  .clk          (clk),
  .rst          (rst),
  .req_valid    (req.valid),
  .req_ready    (req.ready),
  .req_func     (req.func),
  .rsp_valid    (rsp.valid),
  .rsp_ready    (rsp.ready),
  .rsp_ancestor (rsp.ancestor),
  .rsp_bad_node (rsp.bad_node)
);
